[design/awsrch_pkg.sv]
// Shared types and command codes for the anagram window search block.
package awsrch_pkg;

   // Command codes carried in the cmd field of a request word
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_PATTERN = 2'd1;
   localparam logic [1:0] CMD_TEXT    = 2'd2;

   localparam int BYTE_W    = 8;
   localparam int OUT_POS_W = 16;
   localparam int NZ_W      = 9;
   localparam int NZ_MAX    = 256;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [BYTE_W-1:0] data_char;
   } req_type;

   typedef struct packed {
      logic                 match_now;
      logic                 found;
      logic [OUT_POS_W-1:0] match_start;
      logic [OUT_POS_W-1:0] match_end;
   } rsp_type;

   // Control of the deficit table port
   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [BYTE_W-1:0] wr_addr;
      logic [BYTE_W-1:0] rd_addr;
   } count_ctl_type;

endpackage

[design/anagram_window_search.sv]
// Top level of the anagram window search: command front end, table pipeline, result queue.
//
// Usage: send request words on req_ (cmd, data_char). A clear word starts a
// new search, pattern words load the pattern one byte at a time, and text
// words are scanned. Every request word yields exactly one response word on
// rsp_: match_now tells whether the last pattern-length text bytes are a
// permutation of the pattern, and found, match_start and match_end hold the
// first such window since the last clear (end is exclusive).
// An accepted request word passes the first-pass and second-pass stages and is
// then registered in the output queue, which drives rsp_valid.
// Each request word makes two read-modify-write passes over the deficit table,
// which has one read and one write port, so a new word is taken while the
// previous one is in its second pass.
// Reset clears all search state at once (the deficit table through its valid
// bits); no clearing pass is needed. A clear word does the same.
// When the receiver stalls, up to two response words wait in the output
// queue; besides the cycle after each accepted word, req_ready drops only
// when no room would remain for a new word.
module anagram_window_search #(
   parameter int MAX_PATTERN = 64,
   parameter int POS_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  awsrch_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output awsrch_pkg::rsp_type rsp_data
);

   localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
   localparam int SLOT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_W  = $clog2(MAX_PATTERN + 1) + 1;
   localparam int CALC_W = ((POS_BITS > PLEN_W) ? POS_BITS : PLEN_W) + 1;
   localparam int EXT_W  = POS_BITS + awsrch_pkg::OUT_POS_W;
   localparam int BW     = awsrch_pkg::BYTE_W;
   localparam int NW     = awsrch_pkg::NZ_W;

   // Front state
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                full_ff, full_in;

   // First pass stage
   logic                s1_valid_ff;
   logic                s1_a_en_ff;
   logic                s1_a_dec_ff;
   logic                s1_b_en_ff;
   logic                s1_elig_ff;
   logic [BW-1:0]       s1_char_ff;
   logic [POS_BITS-1:0] s1_start_ff;
   logic [POS_BITS-1:0] s1_end_ff;

   // Second pass stage
   logic                s2_valid_ff;
   logic                s2_b_en_ff;
   logic                s2_elig_ff;
   logic [BW-1:0]       s2_leave_ff;
   logic [POS_BITS-1:0] s2_start_ff;
   logic [POS_BITS-1:0] s2_end_ff;

   // Search status
   logic [NW-1:0]       nz_ff, nz_in;
   logic                found_ff, found_in;
   logic [POS_BITS-1:0] first_start_ff, first_start_in;
   logic [POS_BITS-1:0] first_end_ff, first_end_in;

   logic                accept;
   logic                is_clear, is_pat, is_text;
   logic                slot_at_end;
   logic                pat_take, text_take, text_win;
   logic [CALC_W-1:0]   end_calc, start_calc;

   awsrch_pkg::count_ctl_type cm_ctl;
   logic [CNT_W-1:0]          cm_value;
   logic [CNT_W-1:0]          new1, new2, cm_wdata;
   logic [BW-1:0]             wm_rdata;
   logic                      up1, down1, up2, down2;
   logic [NW-1:0]             nz_mid, nz_after;
   logic                      now;
   logic                      hit_first;
   logic                      res_found;
   logic [POS_BITS-1:0]       res_start, res_end;
   logic [EXT_W-1:0]          start_ext, end_ext;
   awsrch_pkg::rsp_type       res_word;
   logic [1:0]                q_level;
   logic [2:0]                q_claim;

   // Admission: no word in its first pass, and room in the queue
   assign q_claim   = {1'b0, q_level} + {2'b00, s2_valid_ff};
   assign req_ready = !s1_valid_ff && (q_claim < 3'd2);
   assign accept    = req_valid && req_ready;

   // Command decode
   assign is_clear    = (req_data.cmd == awsrch_pkg::CMD_CLEAR);
   assign is_pat      = (req_data.cmd == awsrch_pkg::CMD_PATTERN);
   assign is_text     = (req_data.cmd == awsrch_pkg::CMD_TEXT);
   assign slot_at_end = (PLEN_W'(slot_ff) == (plen_ff - PLEN_W'(1)));
   assign pat_take    = accept && is_pat && (pos_ff == '0) &&
                        (plen_ff < PLEN_W'(MAX_PATTERN));
   assign text_take   = accept && is_text && (pos_ff != '1);
   assign text_win    = text_take && (plen_ff != '0);

   // Window bounds for a match ending at this byte
   assign end_calc   = CALC_W'(pos_ff) + CALC_W'(1);
   assign start_calc = end_calc - CALC_W'(plen_ff);

   // Front state update
   always_comb begin
      pos_in  = pos_ff;
      plen_in = plen_ff;
      slot_in = slot_ff;
      full_in = full_ff;
      if (accept && is_clear) begin
         pos_in  = '0;
         plen_in = '0;
         slot_in = '0;
         full_in = 1'b0;
      end else if (pat_take) begin
         plen_in = plen_ff + PLEN_W'(1);
      end else if (text_take) begin
         pos_in = pos_ff + POS_BITS'(1);
         if (text_win) begin
            slot_in = slot_at_end ? '0 : slot_ff + SLOT_W'(1);
            full_in = full_ff || slot_at_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         plen_ff <= '0;
         slot_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         plen_ff <= plen_in;
         slot_ff <= slot_in;
         full_ff <= full_in;
      end
   end

   // Pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_a_en_ff  <= pat_take || text_win;
      s1_a_dec_ff <= text_win;
      s1_b_en_ff  <= text_win && full_ff;
      s1_elig_ff  <= text_win && (full_ff || slot_at_end);
      s1_char_ff  <= req_data.data_char;
      s1_start_ff <= POS_BITS'(start_calc);
      s1_end_ff   <= POS_BITS'(end_calc);
      s2_b_en_ff  <= s1_b_en_ff;
      s2_elig_ff  <= s1_elig_ff;
      s2_leave_ff <= wm_rdata;
      s2_start_ff <= s1_start_ff;
      s2_end_ff   <= s1_end_ff;
   end

   // Text byte ring
   awsrch_window_mem #(
      .DEPTH  (MAX_PATTERN),
      .ADDR_W (SLOT_W)
   ) u_window (
      .clock   (clock),
      .wr_en   (text_win),
      .addr    (slot_ff),
      .wr_data (req_data.data_char),
      .rd_data (wm_rdata)
   );

   // Table passes: entering byte in the first, leaving byte in the second
   assign new1     = s1_a_dec_ff ? (cm_value - CNT_W'(1)) : (cm_value + CNT_W'(1));
   assign new2     = cm_value + CNT_W'(1);
   assign cm_wdata = s1_valid_ff ? new1 : new2;

   always_comb begin
      cm_ctl.clear   = accept && is_clear;
      cm_ctl.wr_en   = (s1_valid_ff && s1_a_en_ff) || (s2_valid_ff && s2_b_en_ff);
      cm_ctl.wr_addr = s1_valid_ff ? s1_char_ff : s2_leave_ff;
      cm_ctl.rd_addr = s1_valid_ff ? wm_rdata : req_data.data_char;
   end

   awsrch_count_mem #(
      .CNT_W (CNT_W)
   ) u_count (
      .clock    (clock),
      .reset    (reset),
      .ctl      (cm_ctl),
      .wr_data  (cm_wdata),
      .rd_value (cm_value)
   );

   // Count of byte values whose deficit is nonzero
   always_comb begin
      up1      = s1_valid_ff && s1_a_en_ff && (cm_value == '0);
      down1    = s1_valid_ff && s1_a_en_ff && (cm_value != '0) && (new1 == '0);
      up2      = s2_valid_ff && s2_b_en_ff && (cm_value == '0);
      down2    = s2_valid_ff && s2_b_en_ff && (cm_value != '0) && (new2 == '0);
      nz_mid   = nz_ff + NW'(up1) - NW'(down1);
      nz_after = nz_mid + NW'(up2) - NW'(down2);
      nz_in    = cm_ctl.clear ? '0 : nz_after;
   end

   // Match decision and first-match capture
   always_comb begin
      now       = s2_valid_ff && s2_elig_ff && (nz_after == '0);
      hit_first = now && !found_ff;
      res_found = found_ff || hit_first;
      res_start = hit_first ? s2_start_ff : first_start_ff;
      res_end   = hit_first ? s2_end_ff : first_end_ff;
      if (cm_ctl.clear) begin
         found_in       = 1'b0;
         first_start_in = '0;
         first_end_in   = '0;
      end else begin
         found_in       = res_found;
         first_start_in = res_start;
         first_end_in   = res_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff          <= '0;
         found_ff       <= 1'b0;
         first_start_ff <= '0;
         first_end_ff   <= '0;
      end else begin
         nz_ff          <= nz_in;
         found_ff       <= found_in;
         first_start_ff <= first_start_in;
         first_end_ff   <= first_end_in;
      end
   end

   // Response word
   assign start_ext = {{awsrch_pkg::OUT_POS_W{1'b0}}, res_start};
   assign end_ext   = {{awsrch_pkg::OUT_POS_W{1'b0}}, res_end};

   always_comb begin
      res_word.match_now   = now;
      res_word.found       = res_found;
      res_word.match_start = start_ext[awsrch_pkg::OUT_POS_W-1:0];
      res_word.match_end   = end_ext[awsrch_pkg::OUT_POS_W-1:0];
   end

   awsrch_rsp_fifo u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (res_word),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .level     (q_level)
   );

   // Checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff))
      else $error("two words inside the table pipeline at once");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (q_level < 2'd2))
      else $error("response queue full when a word completes");

   a_nz_bound: assert property (@(posedge clock) disable iff (reset)
      nz_ff <= NW'(awsrch_pkg::NZ_MAX))
      else $error("nonzero count beyond number of byte values");

   a_match_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.match_now |-> rsp_data.found)
      else $error("match reported without found set");

   a_no_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         (rsp_data.match_start == '0) && (rsp_data.match_end == '0))
      else $error("match bounds nonzero before any match");

endmodule

[design/awsrch_count_mem.sv]
// Deficit table: 256-entry count memory with per-entry valid bits and write forwarding.
module awsrch_count_mem #(
   parameter int CNT_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  awsrch_pkg::count_ctl_type ctl,
   input  logic [CNT_W-1:0]          wr_data,
   output logic [CNT_W-1:0]          rd_value
);

   localparam int ENTRIES = 1 << awsrch_pkg::BYTE_W;

   logic [CNT_W-1:0]              count_mem [ENTRIES];
   logic [ENTRIES-1:0]            valid_ff;
   logic [CNT_W-1:0]              rd_data_ff;
   logic                          rd_valid_ff;
   logic [awsrch_pkg::BYTE_W-1:0] rd_addr_ff;
   logic                          fwd_en_ff;
   logic [awsrch_pkg::BYTE_W-1:0] fwd_addr_ff;
   logic [CNT_W-1:0]              fwd_data_ff;

   // Memory array: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         count_mem[ctl.wr_addr] <= wr_data;
      end
      rd_data_ff <= count_mem[ctl.rd_addr];
      rd_addr_ff <= ctl.rd_addr;
      fwd_addr_ff <= ctl.wr_addr;
      fwd_data_ff <= wr_data;
   end

   // Valid bits: a clear drops every entry back to zero at once
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_en_ff   <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[ctl.rd_addr];
         fwd_en_ff   <= ctl.wr_en;
      end
   end

   // A write in the read cycle is not in the read word; take it from the bypass
   always_comb begin
      if (fwd_en_ff && (fwd_addr_ff == rd_addr_ff)) begin
         rd_value = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_value = rd_data_ff;
      end else begin
         rd_value = '0;
      end
   end

endmodule

[design/awsrch_window_mem.sv]
// Delay line of recent text bytes, kept as a ring in a synchronous memory.
module awsrch_window_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             addr,
   input  logic [awsrch_pkg::BYTE_W-1:0] wr_data,
   output logic [awsrch_pkg::BYTE_W-1:0] rd_data
);

   logic [awsrch_pkg::BYTE_W-1:0] win_mem [DEPTH];
   logic [awsrch_pkg::BYTE_W-1:0] rd_data_ff;

   // Read returns the old byte of the slot being overwritten
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[addr] <= wr_data;
      end
      rd_data_ff <= win_mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/awsrch_rsp_fifo.sv]
// Two-entry output queue for response words.
module awsrch_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  awsrch_pkg::rsp_type push_data,
   input  logic                pop_ready,
   output logic                out_valid,
   output awsrch_pkg::rsp_type out_data,
   output logic [1:0]          level
);

   awsrch_pkg::rsp_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          level_ff;
   logic [1:0]          level_in;
   logic                pop;

   assign out_valid = (level_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = out_valid && pop_ready;

   // Pointer and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[tb/anagram_window_search_tb.sv]
// Self-checking testbench for the anagram window search block.
module anagram_window_search_tb;

   localparam int          PATTERN_DEPTH = 64;
   localparam int unsigned POS_LIMIT     = 65535;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam int          USEFUL_TARGET = 1800;

   // Scoreboard: tracks the search state and queues the expected response words
   class match_scoreboard;
      int                  deficit [256];
      int unsigned         nonzero_values;
      int unsigned         pat_len;
      logic [7:0]          recent_text [PATTERN_DEPTH];
      int unsigned         text_pos;
      bit                  seen_match;
      int unsigned         first_lo;
      int unsigned         first_hi;
      awsrch_pkg::rsp_type expected_words [$];
      int unsigned         mismatches;
      int unsigned         checked;
      int unsigned         match_count;
      int unsigned         text_words;

      function new();
         restart();
         mismatches  = 0;
         checked     = 0;
         match_count = 0;
         text_words  = 0;
      endfunction

      function void restart();
         foreach (deficit[i]) deficit[i] = 0;
         nonzero_values = 0;
         pat_len        = 0;
         text_pos       = 0;
         seen_match     = 0;
         first_lo       = 0;
         first_hi       = 0;
      endfunction

      function void shift_count(logic [7:0] value, int delta);
         int old_count;
         old_count      = deficit[value];
         deficit[value] = old_count + delta;
         if (old_count == 0 && deficit[value] != 0) begin
            nonzero_values++;
         end else if (old_count != 0 && deficit[value] == 0) begin
            nonzero_values--;
         end
      endfunction

      // Returns 1 when the word changed the search state
      function bit note_word(awsrch_pkg::req_type w);
         awsrch_pkg::rsp_type want;
         bit                  hit;
         bit                  took;
         int unsigned         slot;
         hit  = 1'b0;
         took = 1'b0;
         case (w.cmd)
            awsrch_pkg::CMD_CLEAR: begin
               restart();
               took = 1'b1;
            end
            awsrch_pkg::CMD_PATTERN: begin
               // pattern is frozen once text has started, and capped in length
               if (text_pos == 0 && pat_len < PATTERN_DEPTH) begin
                  shift_count(w.data_char, 1);
                  pat_len++;
                  took = 1'b1;
               end
            end
            awsrch_pkg::CMD_TEXT: begin
               // saturated position: byte dropped
               if (text_pos < POS_LIMIT) begin
                  if (pat_len != 0) begin
                     slot = text_pos % pat_len;
                     if (text_pos >= pat_len) shift_count(recent_text[slot], 1);
                     shift_count(w.data_char, -1);
                     recent_text[slot] = w.data_char;
                     if (nonzero_values == 0 && text_pos + 1 >= pat_len) begin
                        hit = 1'b1;
                        match_count++;
                        if (!seen_match) begin
                           seen_match = 1'b1;
                           first_lo   = text_pos + 1 - pat_len;
                           first_hi   = text_pos + 1;
                        end
                     end
                  end
                  text_pos++;
                  text_words++;
                  took = 1'b1;
               end
            end
            default: ;
         endcase
         want.match_now   = hit;
         want.found       = seen_match;
         want.match_start = 16'(first_lo);
         want.match_end   = 16'(first_hi);
         expected_words.push_back(want);
         return took;
      endfunction

      function void check_word(awsrch_pkg::rsp_type got);
         awsrch_pkg::rsp_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: now=%0b found=%0b start=%0d end=%0d",
                        got.match_now, got.found, got.match_start, got.match_end);
            return;
         end
         want = expected_words.pop_front();
         if (got.match_now !== want.match_now || got.found !== want.found ||
             got.match_start !== want.match_start || got.match_end !== want.match_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"response %0d: expected now=%0b found=%0b start=%0d end=%0d,",
                         " got now=%0b found=%0b start=%0d end=%0d"},
                        checked, want.match_now, want.found, want.match_start,
                        want.match_end, got.match_now, got.found, got.match_start,
                        got.match_end);
         end
         checked++;
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   awsrch_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   awsrch_pkg::rsp_type rsp_data;

   match_scoreboard scoreboard = new();
   int unsigned     idle_odds    = 0;
   int unsigned     stall_odds   = 0;
   int unsigned     useful_words = 0;
   int unsigned     sent_words   = 0;

   anagram_window_search DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random stall bursts while stall_odds is nonzero
   always begin
      @(negedge clock);
      if (!reset && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 18) - 1) @(negedge clock);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Response check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) scoreboard.check_word(rsp_data);
   end

   task automatic pause_sender(int unsigned cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_word(logic [1:0] cmd, logic [7:0] ch);
      awsrch_pkg::req_type w;
      w.cmd       = cmd;
      w.data_char = ch;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_words++;
      if (scoreboard.note_word(w)) useful_words++;
      if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
         pause_sender($urandom_range(1, 18));
   endtask

   // Sender goes idle, then waits for every outstanding response word
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (scoreboard.expected_words.size() != 0) @(posedge clock);
   endtask

   // One search: usual clear, pattern from small alphabet, text mostly from it, noise
   task automatic run_search();
      logic [7:0]  alphabet [4];
      int unsigned alpha_n;
      int unsigned plen;
      int unsigned tlen;
      int unsigned sel;
      int          i;
      idle_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      if ($urandom_range(0, 9) != 0) send_word(awsrch_pkg::CMD_CLEAR, 8'($urandom));
      alpha_n = $urandom_range(1, 4);
      for (i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(0, 255));
      sel = $urandom_range(0, 19);
      if (sel == 0)     plen = 0;
      else if (sel == 1) plen = $urandom_range(60, 70);
      else if (sel < 5)  plen = $urandom_range(9, 40);
      else               plen = $urandom_range(1, 8);
      for (i = 0; i < plen; i++)
         send_word(awsrch_pkg::CMD_PATTERN, alphabet[$urandom_range(0, alpha_n - 1)]);
      tlen = $urandom_range(0, 3 * plen + 12);
      for (i = 0; i < tlen; i++) begin
         sel = $urandom_range(0, 39);
         if (sel == 0)      send_word(awsrch_pkg::CMD_PATTERN, 8'($urandom));
         else if (sel == 1) send_word(CMD_UNUSED, 8'($urandom));
         else if (sel == 2) send_word(awsrch_pkg::CMD_CLEAR, 8'($urandom));
         else if (sel < 7)  send_word(awsrch_pkg::CMD_TEXT, 8'($urandom_range(0, 255)));
         else               send_word(awsrch_pkg::CMD_TEXT,
                                      alphabet[$urandom_range(0, alpha_n - 1)]);
      end
   endtask

   // Run-time limit
   initial begin
      #6_000_000;
      $display("anagram_window_search: mismatch");
      $finish;
   end

   initial begin
      int unsigned k;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pattern, unused command, extreme bytes, late pattern
      send_word(awsrch_pkg::CMD_CLEAR, 8'hFF);
      send_word(awsrch_pkg::CMD_TEXT, 8'h00);
      send_word(awsrch_pkg::CMD_TEXT, 8'hFF);
      send_word(CMD_UNUSED, 8'hFF);
      send_word(awsrch_pkg::CMD_CLEAR, 8'h00);
      send_word(awsrch_pkg::CMD_PATTERN, 8'h00);
      send_word(awsrch_pkg::CMD_PATTERN, 8'hFF);
      send_word(awsrch_pkg::CMD_TEXT, 8'hFF);
      send_word(awsrch_pkg::CMD_TEXT, 8'h00);
      send_word(awsrch_pkg::CMD_TEXT, 8'h00);
      send_word(awsrch_pkg::CMD_TEXT, 8'hFF);
      send_word(awsrch_pkg::CMD_PATTERN, 8'h55);
      send_word(CMD_UNUSED, 8'hAA);
      send_word(awsrch_pkg::CMD_TEXT, 8'h00);
      send_word(awsrch_pkg::CMD_CLEAR, 8'h5A);
      send_word(awsrch_pkg::CMD_PATTERN, 8'h80);
      send_word(awsrch_pkg::CMD_TEXT, 8'h80);
      send_word(awsrch_pkg::CMD_TEXT, 8'h01);
      send_word(awsrch_pkg::CMD_TEXT, 8'h80);
      send_word(CMD_UNUSED, 8'h00);

      // hold off until the block has answered everything
      wait_drained();

      while (useful_words < USEFUL_TARGET) begin
         run_search();
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
      wait_drained();

      // full-rate tail: no idling, no stalls, matches late in the text
      idle_odds  = 0;
      stall_odds = 0;
      send_word(awsrch_pkg::CMD_CLEAR, 8'h00);
      send_word(awsrch_pkg::CMD_PATTERN, 8'hA5);
      send_word(awsrch_pkg::CMD_PATTERN, 8'h5A);
      for (k = 0; k < 24; k++)
         send_word(awsrch_pkg::CMD_TEXT, 8'($urandom_range(0, 8'h50)));
      send_word(awsrch_pkg::CMD_TEXT, 8'hA5);
      send_word(awsrch_pkg::CMD_TEXT, 8'h5A);
      send_word(awsrch_pkg::CMD_TEXT, 8'h5A);
      send_word(awsrch_pkg::CMD_TEXT, 8'hA5);
      send_word(awsrch_pkg::CMD_TEXT, 8'h5A);
      @(negedge clock);
      req_valid <= 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);

      $display("run covered %0d request words (%0d text bytes) and saw %0d window matches;",
               sent_words, scoreboard.text_words, scoreboard.match_count);
      $display("%0d response words checked, %0d mismatches", scoreboard.checked,
               scoreboard.mismatches);
      if (scoreboard.mismatches == 0 && scoreboard.expected_words.size() == 0) begin
         $display("anagram_window_search: match");
      end else begin
         $display("anagram_window_search: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
design/awsrch_pkg.sv
design/awsrch_count_mem.sv
design/awsrch_window_mem.sv
design/awsrch_rsp_fifo.sv
design/anagram_window_search.sv
tb/anagram_window_search_tb.sv
